/* hdl/nlwt_pkg.sv */
// Shared types and constants for the noise level window tracker.
`timescale 1ns / 1ps

package nlwt_pkg;

    localparam int DEADBAND_W = 4;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 4'd2;

    localparam int OUT_W = 10;
    localparam int SUM_W = 16;

    typedef struct packed {
        logic eval;
        logic dev_full;
    } item_flags_t;

endpackage

/* hdl/nlwt_sample_win.sv */
// Sample window: window memory, fill/head tracking, running sum, mean and deviation.
`timescale 1ns / 1ps

module nlwt_sample_win #(
    parameter int WINDOW      = 100,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [nlwt_pkg::DEADBAND_W-1:0]  deadband,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [SAMPLE_BITS-1:0]           in_sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [SAMPLE_BITS-1:0]           out_sample,
    output logic [SAMPLE_BITS-1:0]           out_mean,
    output logic [SAMPLE_BITS-1:0]           out_dist,
    output nlwt_pkg::item_flags_t            out_flags
);
    import nlwt_pkg::*;

    localparam int LW = $clog2(WINDOW);
    localparam int FW = $clog2(WINDOW + 1);
    localparam int TW = SAMPLE_BITS + LW;
    localparam int SH = TW + LW;
    localparam int MW = TW + 1;
    localparam int PW = TW + MW;
    // exact for every total below 2**TW
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [MW-1:0] MULT = MW'(RECIP);

    logic [SAMPLE_BITS-1:0] ram [WINDOW];
    logic [SAMPLE_BITS-1:0] ram_rd_reg;

    logic [FW-1:0] fill_reg, fill_next;
    logic [LW-1:0] head_reg, head_next;
    logic [TW-1:0] total_reg, total_next;
    logic          full;
    logic [LW-1:0] wr_addr;

    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic                   take1, take2, take3, take4;
    logic                   load1, load2, load3, load4;
    logic [SAMPLE_BITS-1:0] s1_reg, s2_reg, s3_reg, s4_reg;
    logic                   ev1_reg, ev2_reg, ev3_reg, ev4_reg;
    logic [TW-1:0]          tot2_reg;
    logic [PW-1:0]          prod3_reg;
    logic [SAMPLE_BITS-1:0] mean4_reg, dist4_reg;

    logic [SAMPLE_BITS-1:0] mean3, diff3, dist3, db_ext;

    // elastic stage chain
    assign take4 = !v4_reg || out_ready;
    assign take3 = !v3_reg || take4;
    assign take2 = !v2_reg || take3;
    assign take1 = !v1_reg || take2;
    assign load4 = v3_reg && take4;
    assign load3 = v2_reg && take3;
    assign load2 = v1_reg && take2;
    assign load1 = in_valid && take1;
    assign in_ready = take1;

    assign full    = (fill_reg == FW'(WINDOW));
    assign wr_addr = full ? head_reg : fill_reg[LW-1:0];

    always_comb begin
        fill_next = fill_reg;
        head_next = head_reg;
        if (load1) begin
            if (full) begin
                head_next = (head_reg == LW'(WINDOW - 1)) ? '0 : head_reg + 1'b1;
            end else begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb begin
        total_next = total_reg;
        if (load2) begin
            if (ev1_reg) begin
                total_next = total_reg - TW'(ram_rd_reg) + TW'(s1_reg);
            end else begin
                total_next = total_reg + TW'(s1_reg);
            end
        end
    end

    // read-first: old entry comes out while the new sample goes in
    always_ff @(posedge aclk) begin
        if (load1) begin
            ram_rd_reg   <= ram[wr_addr];
            ram[wr_addr] <= in_sample;
        end
    end

    always_comb begin
        db_ext = SAMPLE_BITS'(deadband);
        mean3  = prod3_reg[SH +: SAMPLE_BITS];
        diff3  = (mean3 > s3_reg) ? (mean3 - s3_reg) : (s3_reg - mean3);
        dist3  = (diff3 <= db_ext) ? '0 : (diff3 - db_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            head_reg  <= '0;
            total_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            total_reg <= total_next;
            if (take1) v1_reg <= in_valid;
            if (take2) v2_reg <= v1_reg;
            if (take3) v3_reg <= v2_reg;
            if (take4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            s1_reg  <= in_sample;
            ev1_reg <= full;
        end
        if (load2) begin
            s2_reg   <= s1_reg;
            ev2_reg  <= ev1_reg;
            tot2_reg <= total_next;
        end
        if (load3) begin
            s3_reg    <= s2_reg;
            ev3_reg   <= ev2_reg;
            prod3_reg <= PW'(tot2_reg) * PW'(MULT);
        end
        if (load4) begin
            s4_reg    <= s3_reg;
            ev4_reg   <= ev3_reg;
            mean4_reg <= mean3;
            dist4_reg <= dist3;
        end
    end

    assign out_valid          = v4_reg;
    assign out_sample         = s4_reg;
    assign out_mean           = mean4_reg;
    assign out_dist           = dist4_reg;
    assign out_flags.eval     = ev4_reg;
    assign out_flags.dev_full = 1'b0;

endmodule

/* hdl/nlwt_dev_win.sv */
// Deviation window: deviation memory, fill/head tracking, running sum and mean.
`timescale 1ns / 1ps

module nlwt_dev_win #(
    parameter int DEV_WINDOW  = 60,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [SAMPLE_BITS-1:0]                        in_sample,
    input  logic [SAMPLE_BITS-1:0]                        in_mean,
    input  logic [SAMPLE_BITS-1:0]                        in_dist,
    input  nlwt_pkg::item_flags_t                         in_flags,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [SAMPLE_BITS-1:0]                        out_sample,
    output logic [SAMPLE_BITS-1:0]                        out_mean,
    output logic [SAMPLE_BITS-1:0]                        out_dist,
    output logic [SAMPLE_BITS+$clog2(DEV_WINDOW)-1:0]     out_sum,
    output logic [SAMPLE_BITS-1:0]                        out_dmean,
    output nlwt_pkg::item_flags_t                         out_flags
);
    import nlwt_pkg::*;

    localparam int LW = $clog2(DEV_WINDOW);
    localparam int FW = $clog2(DEV_WINDOW + 1);
    localparam int TW = SAMPLE_BITS + LW;
    localparam int SH = TW + LW;
    localparam int MW = TW + 1;
    localparam int PW = TW + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DEV_WINDOW) - 64'd1) / 64'(DEV_WINDOW);
    localparam logic [MW-1:0] MULT = MW'(RECIP);

    logic [SAMPLE_BITS-1:0] ram [DEV_WINDOW];
    logic [SAMPLE_BITS-1:0] ram_rd_reg;

    logic [FW-1:0] fill_reg, fill_next;
    logic [LW-1:0] head_reg, head_next;
    logic [TW-1:0] total_reg, total_next;
    logic          full;
    logic [LW-1:0] wr_addr;

    logic                   v1_reg, v2_reg, v3_reg;
    logic                   take1, take2, take3;
    logic                   load1, load2, load3;
    logic [SAMPLE_BITS-1:0] s1_reg, s2_reg, s3_reg;
    logic [SAMPLE_BITS-1:0] m1_reg, m2_reg, m3_reg;
    logic [SAMPLE_BITS-1:0] d1_reg, d2_reg, d3_reg;
    item_flags_t            f1_reg, f2_reg, f3_reg;
    logic [TW-1:0]          tot2_reg, tot3_reg;
    logic [PW-1:0]          prod3_reg;

    assign take3 = !v3_reg || out_ready;
    assign take2 = !v2_reg || take3;
    assign take1 = !v1_reg || take2;
    assign load3 = v2_reg && take3;
    assign load2 = v1_reg && take2;
    assign load1 = in_valid && take1;
    assign in_ready = take1;

    assign full    = (fill_reg == FW'(DEV_WINDOW));
    assign wr_addr = full ? head_reg : fill_reg[LW-1:0];

    // only evaluated items feed the deviation window
    always_comb begin
        fill_next = fill_reg;
        head_next = head_reg;
        if (load1 && in_flags.eval) begin
            if (full) begin
                head_next = (head_reg == LW'(DEV_WINDOW - 1)) ? '0 : head_reg + 1'b1;
            end else begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb begin
        total_next = total_reg;
        if (load2 && f1_reg.eval) begin
            if (f1_reg.dev_full) begin
                total_next = total_reg - TW'(ram_rd_reg) + TW'(d1_reg);
            end else begin
                total_next = total_reg + TW'(d1_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load1 && in_flags.eval) begin
            ram_rd_reg   <= ram[wr_addr];
            ram[wr_addr] <= in_dist;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            head_reg  <= '0;
            total_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            total_reg <= total_next;
            if (take1) v1_reg <= in_valid;
            if (take2) v2_reg <= v1_reg;
            if (take3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            s1_reg          <= in_sample;
            m1_reg          <= in_mean;
            d1_reg          <= in_dist;
            f1_reg.eval     <= in_flags.eval;
            f1_reg.dev_full <= full;
        end
        if (load2) begin
            s2_reg   <= s1_reg;
            m2_reg   <= m1_reg;
            d2_reg   <= d1_reg;
            f2_reg   <= f1_reg;
            tot2_reg <= total_next;
        end
        if (load3) begin
            s3_reg    <= s2_reg;
            m3_reg    <= m2_reg;
            d3_reg    <= d2_reg;
            f3_reg    <= f2_reg;
            tot3_reg  <= tot2_reg;
            prod3_reg <= PW'(tot2_reg) * PW'(MULT);
        end
    end

    assign out_valid  = v3_reg;
    assign out_sample = s3_reg;
    assign out_mean   = m3_reg;
    assign out_dist   = d3_reg;
    assign out_flags  = f3_reg;
    assign out_sum    = tot3_reg;
    assign out_dmean  = prod3_reg[SH +: SAMPLE_BITS];

endmodule

/* hdl/noise_level_window_tracker.sv */
// Top level of the noise level window tracker: deadband register and held result register.
`timescale 1ns / 1ps

// Usage:
//   Input channel s_valid/s_ready carries one sample per item. Result
//   channel m_valid/m_ready returns exactly one result item per sample.
//   cfg_wr_en/cfg_wr_data write the 4-bit deadband; write it only while
//   no item is in flight.
//   Each item passes the sample-window stages, deviation-window stages and output register.
//   Throughput: one item per cycle unless m_ready stalls. Each window memory has a single
//   read-first port that reads the oldest entry while it writes the new
//   one, and each running sum register is updated at most once per item.
//   Before a window is full its statistics are not loaded; the result
//   fields fed by that window repeat their last values, zero after
//   reset. Reset empties both windows, clears the held results and sets
//   the deadband to 2. No clearing pass is needed.
//   When the receiver stalls, the result waits in the output register
//   and the internal stages keep taking items until every stage is
//   occupied; only then does s_ready drop.
module noise_level_window_tracker #(
    parameter int WINDOW      = 100,
    parameter int DEV_WINDOW  = 60,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [nlwt_pkg::DEADBAND_W-1:0]  cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [SAMPLE_BITS-1:0]           s_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [nlwt_pkg::OUT_W-1:0]       m_sample_echo,
    output logic [nlwt_pkg::OUT_W-1:0]       m_window_mean,
    output logic [nlwt_pkg::OUT_W-1:0]       m_deviation,
    output logic [nlwt_pkg::SUM_W-1:0]       m_deviation_sum,
    output logic [nlwt_pkg::OUT_W-1:0]       m_deviation_mean
);
    import nlwt_pkg::*;

    localparam int DTW = SAMPLE_BITS + $clog2(DEV_WINDOW);

    logic [DEADBAND_W-1:0] deadband_reg;

    logic                   sw_valid, sw_ready;
    logic [SAMPLE_BITS-1:0] sw_sample, sw_mean, sw_dist;
    item_flags_t            sw_flags;

    logic                   dv_valid;
    logic [SAMPLE_BITS-1:0] dv_sample, dv_mean, dv_dist, dv_dmean;
    logic [DTW-1:0]         dv_sum;
    item_flags_t            dv_flags;

    logic                   m_valid_reg;
    logic [OUT_W-1:0]       echo_reg, wmean_reg, dev_reg, dmean_reg;
    logic [SUM_W-1:0]       dsum_reg;
    logic                   out_take, out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg <= DEADBAND_RESET;
        end else if (cfg_wr_en) begin
            deadband_reg <= cfg_wr_data;
        end
    end

    nlwt_sample_win #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sample_win (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .deadband   (deadband_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_sample  (s_sample),
        .out_valid  (sw_valid),
        .out_ready  (sw_ready),
        .out_sample (sw_sample),
        .out_mean   (sw_mean),
        .out_dist   (sw_dist),
        .out_flags  (sw_flags)
    );

    nlwt_dev_win #(
        .DEV_WINDOW  (DEV_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dev_win (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (sw_valid),
        .in_ready   (sw_ready),
        .in_sample  (sw_sample),
        .in_mean    (sw_mean),
        .in_dist    (sw_dist),
        .in_flags   (sw_flags),
        .out_valid  (dv_valid),
        .out_ready  (out_take),
        .out_sample (dv_sample),
        .out_mean   (dv_mean),
        .out_dist   (dv_dist),
        .out_sum    (dv_sum),
        .out_dmean  (dv_dmean),
        .out_flags  (dv_flags)
    );

    assign out_take = !m_valid_reg || m_ready;
    assign out_load = dv_valid && out_take;

    // the output register doubles as the held results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            echo_reg    <= '0;
            wmean_reg   <= '0;
            dev_reg     <= '0;
            dsum_reg    <= '0;
            dmean_reg   <= '0;
        end else begin
            if (out_take) m_valid_reg <= dv_valid;
            if (out_load) begin
                echo_reg <= OUT_W'(dv_sample);
                if (dv_flags.eval) begin
                    wmean_reg <= OUT_W'(dv_mean);
                    dev_reg   <= OUT_W'(dv_dist);
                    if (dv_flags.dev_full) begin
                        dsum_reg  <= SUM_W'(dv_sum);
                        dmean_reg <= OUT_W'(dv_dmean);
                    end
                end
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sample_echo    = echo_reg;
    assign m_window_mean    = wmean_reg;
    assign m_deviation      = dev_reg;
    assign m_deviation_sum  = dsum_reg;
    assign m_deviation_mean = dmean_reg;

`ifndef NO_ASSERTIONS
    // backpressure only originates from a stalled result
    a_stall_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled result");

    // held statistics change only when an item is loaded
    a_held_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(out_load)) |->
            ($stable(m_window_mean) && $stable(m_deviation) &&
             $stable(m_deviation_sum) && $stable(m_deviation_mean)))
        else $error("held results changed without a new item");

    // a result is only loaded into an empty or draining output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_sample_echo) && m_valid))
        else $error("output register overwritten while stalled");
`endif

endmodule
